// ----- sv/wrsi_pkg.sv -----
// ----------------------------------------------------------------------------
// Wilder RSI tracker package
// Shared widths, constants and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package wrsi_pkg;

    localparam int unsigned ACC_BITS     = 56;
    localparam int unsigned SUM_BITS     = ACC_BITS + 1;
    localparam int unsigned PROD_BITS    = 64;
    localparam int unsigned RSI_BITS     = 23;
    localparam int unsigned CNT_BITS     = 8;
    localparam int unsigned PERIOD_BITS  = 8;
    localparam int unsigned MAX_PERIOD   = 255;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd14;
    localparam logic [6:0]             HUNDRED      = 7'd100;

    typedef struct packed {
        logic capture;
        logic delta;
        logic accum;
        logic divp;
        logic rmul;
        logic rdiv;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic restart;
        logic full;
        logic reach;
        logic loss_zero;
        logic out_busy;
    } t_dp_status;

endpackage

// ----- sv/wrsi_datapath.sv -----
// ----------------------------------------------------------------------------
// Wilder RSI datapath
// Holds the period register, the series state, two radix-2 lanes that divide
// the averages by the period, the radix-2 RSI divider and the output register.
// ----------------------------------------------------------------------------
module wrsi_datapath
    import wrsi_pkg::*;
#(
    parameter int unsigned PRICE_BITS    = 32,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic                   i_cfg_write,
    input  logic [PERIOD_BITS-1:0] i_cfg_period,
    input  logic [PRICE_BITS-1:0]  i_close_price,
    input  logic                   i_restart,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [RSI_BITS-1:0]    o_rsi_value,
    output logic                   o_ready_res
);

    localparam int unsigned DVD_BITS = PROD_BITS + FRACTION_BITS;

    logic [PERIOD_BITS-1:0] r_period;
    logic [PERIOD_BITS-1:0] r_p;
    logic [PRICE_BITS-1:0]  r_close;
    logic                   r_restart;
    logic [PRICE_BITS-1:0]  r_prev;
    logic [CNT_BITS-1:0]    r_count;
    logic [ACC_BITS-1:0]    r_gain;
    logic [ACC_BITS-1:0]    r_loss;
    logic [ACC_BITS-1:0]    r_gain_fx;
    logic [ACC_BITS-1:0]    r_loss_fx;
    logic [ACC_BITS-1:0]    r_gprod;
    logic [ACC_BITS-1:0]    r_lprod;
    logic [PERIOD_BITS-1:0] r_grem;
    logic [PERIOD_BITS-1:0] r_lrem;
    logic [DVD_BITS-1:0]    r_dvd;
    logic [SUM_BITS-1:0]    r_den;
    logic [SUM_BITS-1:0]    r_rrem;
    logic [RSI_BITS-1:0]    r_quot;
    logic                   r_out_valid;
    logic [RSI_BITS-1:0]    r_out_rsi;
    logic                   r_out_ready;

    logic [PERIOD_BITS-1:0] p_eff;
    logic [PERIOD_BITS-1:0] pm1;
    logic                   up;
    logic [PRICE_BITS-1:0]  diff;
    logic [ACC_BITS-1:0]    fx;
    logic [PERIOD_BITS:0]   g_t;
    logic [PERIOD_BITS:0]   l_t;
    logic                   g_ge;
    logic                   l_ge;
    logic [PERIOD_BITS-1:0] g_rem_n;
    logic [PERIOD_BITS-1:0] l_rem_n;
    logic [SUM_BITS:0]      r_t;
    logic                   r_ge;
    logic [SUM_BITS-1:0]    rrem_n;
    logic [RSI_BITS-1:0]    res_val;

    always_comb begin
        p_eff = r_period;
        if (r_period == '0) begin
            p_eff = PERIOD_BITS'(1);
        end
        if (32'(r_period) > MAX_PERIOD) begin
            p_eff = PERIOD_BITS'(MAX_PERIOD);
        end
    end

    assign pm1  = r_p - PERIOD_BITS'(1);
    assign up   = r_close > r_prev;
    assign diff = up ? (r_close - r_prev) : (r_prev - r_close);
    assign fx   = ACC_BITS'({diff, FRACTION_BITS'(0)});

    assign g_t     = {r_grem, r_gain[ACC_BITS-1]};
    assign l_t     = {r_lrem, r_loss[ACC_BITS-1]};
    assign g_ge    = g_t >= {1'b0, r_p};
    assign l_ge    = l_t >= {1'b0, r_p};
    assign g_rem_n = g_ge ? PERIOD_BITS'(g_t - {1'b0, r_p}) : PERIOD_BITS'(g_t);
    assign l_rem_n = l_ge ? PERIOD_BITS'(l_t - {1'b0, r_p}) : PERIOD_BITS'(l_t);

    assign r_t    = {r_rrem, r_dvd[DVD_BITS-1]};
    assign r_ge   = r_t >= {1'b0, r_den};
    assign rrem_n = r_ge ? SUM_BITS'(r_t - {1'b0, r_den}) : SUM_BITS'(r_t);

    always_comb begin
        if (!o_status.full) begin
            res_val = '0;
        end else if (o_status.loss_zero) begin
            res_val = RSI_BITS'({HUNDRED, FRACTION_BITS'(0)});
        end else begin
            res_val = r_quot;
        end
    end

    assign o_status.restart   = r_restart;
    assign o_status.full      = r_count >= r_p;
    assign o_status.reach     = ({1'b0, r_count} + 9'd1) == {1'b0, r_p};
    assign o_status.loss_zero = r_loss == '0;
    assign o_status.out_busy  = r_out_valid & i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_prev      <= '0;
            r_count     <= '0;
            r_gain      <= '0;
            r_loss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_period <= i_cfg_period;
            end
            if (i_cmd.delta) begin
                r_prev <= r_close;
                if (r_restart) begin
                    r_count <= '0;
                    r_gain  <= '0;
                    r_loss  <= '0;
                end
            end
            if (i_cmd.accum) begin
                if (o_status.full) begin
                    r_gain <= r_gprod + r_gain_fx;
                    r_loss <= r_lprod + r_loss_fx;
                end else begin
                    r_gain <= r_gain + r_gain_fx;
                    r_loss <= r_loss + r_loss_fx;
                end
                if (r_count != '1) begin
                    r_count <= r_count + CNT_BITS'(1);
                end
            end
            if (i_cmd.divp) begin
                r_gain <= {r_gain[ACC_BITS-2:0], g_ge};
                r_loss <= {r_loss[ACC_BITS-2:0], l_ge};
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_close   <= i_close_price;
            r_restart <= i_restart;
            r_p       <= p_eff;
        end
        if (i_cmd.delta) begin
            r_gain_fx <= up ? fx : '0;
            r_loss_fx <= up ? '0 : fx;
            r_gprod   <= r_gain * ACC_BITS'(pm1);
            r_lprod   <= r_loss * ACC_BITS'(pm1);
        end
        if (i_cmd.accum) begin
            r_grem <= '0;
            r_lrem <= '0;
        end
        if (i_cmd.divp) begin
            r_grem <= g_rem_n;
            r_lrem <= l_rem_n;
        end
        if (i_cmd.rmul) begin
            r_dvd  <= {PROD_BITS'(r_gain) * PROD_BITS'(HUNDRED), FRACTION_BITS'(0)};
            r_den  <= SUM_BITS'(r_gain) + SUM_BITS'(r_loss);
            r_rrem <= '0;
            r_quot <= '0;
        end
        if (i_cmd.rdiv) begin
            r_rrem <= rrem_n;
            r_dvd  <= {r_dvd[DVD_BITS-2:0], 1'b0};
            r_quot <= {r_quot[RSI_BITS-2:0], r_ge};
        end
        if (i_cmd.load_out) begin
            r_out_rsi   <= res_val;
            r_out_ready <= o_status.full;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rsi_value = r_out_rsi;
    assign o_ready_res = r_out_ready;

endmodule

// ----- sv/wrsi_ctrl.sv -----
// ----------------------------------------------------------------------------
// Wilder RSI controller
// Sequences capture, update, the period divisions, the RSI division and the
// output load for one transaction at a time.
// ----------------------------------------------------------------------------
module wrsi_ctrl
    import wrsi_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam int unsigned R_STEPS = PROD_BITS + FRACTION_BITS;
    localparam int unsigned STEP_W  = $clog2(R_STEPS);
    localparam logic [STEP_W-1:0] P_LAST = STEP_W'(ACC_BITS - 1);
    localparam logic [STEP_W-1:0] R_LAST = STEP_W'(R_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_ACCUM,
        S_DIVP,
        S_CHECK,
        S_RDIV,
        S_OUT
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DELTA;
                end
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state     = S_ACCUM;
            end
            S_ACCUM: begin
                if (i_status.restart) begin
                    n_state = S_CHECK;
                end else begin
                    o_cmd.accum = 1'b1;
                    if (i_status.full || i_status.reach) begin
                        n_state = S_DIVP;
                        n_step  = P_LAST;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_DIVP: begin
                o_cmd.divp = 1'b1;
                if (r_step == '0) begin
                    n_state = S_CHECK;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_CHECK: begin
                if (i_status.full && !i_status.loss_zero) begin
                    o_cmd.rmul = 1'b1;
                    n_state    = S_RDIV;
                    n_step     = R_LAST;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RDIV: begin
                o_cmd.rdiv = 1'b1;
                if (r_step == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

// ----- sv/wilder_rsi_tracker_top.sv -----
// ----------------------------------------------------------------------------
// Wilder RSI tracker top level: one transaction at a time, one result for each.
// A result follows the update, the period division once the window fills, and the RSI
// division when it is full with nonzero loss; the next one is accepted after its load.
// Output stalls delay both. Synchronous active-low reset clears the series, period is 14.
// ----------------------------------------------------------------------------
module wilder_rsi_tracker_top
    import wrsi_pkg::*;
#(
    parameter int unsigned PRICE_BITS    = 32,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [PRICE_BITS-1:0]  i_close_price,
    input  logic                   i_restart,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [RSI_BITS-1:0]    o_rsi_value,
    output logic                   o_ready_res,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [PERIOD_BITS-1:0] i_cfg_period
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    wrsi_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wrsi_datapath #(
        .PRICE_BITS   (PRICE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_write   (i_cfg_valid & o_cfg_ready),
        .i_cfg_period  (i_cfg_period),
        .i_close_price (i_close_price),
        .i_restart     (i_restart),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_rsi_value   (o_rsi_value),
        .o_ready_res   (o_ready_res)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input not stalled after an accepted transaction.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !(o_out_valid && i_out_stall))
        else $error("Output register loaded while a result is still held.");

    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ready_res) |-> (o_rsi_value == '0))
        else $error("Nonzero RSI reported before the window is full.");
`endif

endmodule

// ----- tb/sv/wrsi_checker.sv -----
// ----------------------------------------------------------------------------
// Wilder RSI tracker checker
// Watches the configuration, input and result channels of the tracker. It
// keeps its own copy of the series state, predicts each result, and compares
// every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module wrsi_checker
    import wrsi_pkg::*;
#(
    parameter int unsigned PRICE_BITS    = 32,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [PRICE_BITS-1:0]  i_close_price,
    input  logic                   i_restart,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [RSI_BITS-1:0]    i_rsi_value,
    input  logic                   i_ready_res,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [PERIOD_BITS-1:0] i_cfg_period,
    output int                     o_fail_count,
    output int                     o_outstanding
);

    typedef struct packed {
        logic [RSI_BITS-1:0] rsi;
        logic                ready;
    } t_rsi_expect;

    logic [PERIOD_BITS-1:0] period_reg;
    logic [PRICE_BITS-1:0]  last_close;
    logic [CNT_BITS-1:0]    seen_changes;
    logic [ACC_BITS-1:0]    gain_avg;
    logic [ACC_BITS-1:0]    loss_avg;
    t_rsi_expect            rsi_expected_q[$];
    int                     fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic t_rsi_expect next_rsi(input logic [PRICE_BITS-1:0] price,
                                             input logic restart);
        logic [63:0]  span;
        logic [63:0]  gain;
        logic [63:0]  loss;
        logic [63:0]  num;
        logic [127:0] quot;
        t_rsi_expect  res;
        span = (period_reg == '0) ? 64'd1 : 64'(period_reg);
        if (span > 64'(MAX_PERIOD)) begin
            span = 64'(MAX_PERIOD);
        end
        res = '0;
        if (restart) begin
            last_close   = price;
            seen_changes = '0;
            gain_avg     = '0;
            loss_avg     = '0;
        end else begin
            gain = '0;
            loss = '0;
            if (price > last_close) begin
                gain = 64'(price - last_close);
            end else begin
                loss = 64'(last_close - price);
            end
            gain = gain << FRACTION_BITS;
            loss = loss << FRACTION_BITS;
            last_close = price;
            if (64'(seen_changes) < span) begin
                gain_avg = ACC_BITS'(64'(gain_avg) + gain);
                loss_avg = ACC_BITS'(64'(loss_avg) + loss);
                seen_changes = seen_changes + 1'b1;
                if (64'(seen_changes) == span) begin
                    gain_avg = ACC_BITS'(64'(gain_avg) / span);
                    loss_avg = ACC_BITS'(64'(loss_avg) / span);
                end
            end else begin
                gain_avg = ACC_BITS'(64'(ACC_BITS'(64'(gain_avg) * (span - 1) + gain)) / span);
                loss_avg = ACC_BITS'(64'(ACC_BITS'(64'(loss_avg) * (span - 1) + loss)) / span);
                if (seen_changes != '1) begin
                    seen_changes = seen_changes + 1'b1;
                end
            end
        end
        if (64'(seen_changes) >= span) begin
            res.ready = 1'b1;
            if (loss_avg == '0) begin
                res.rsi = RSI_BITS'(64'(HUNDRED) << FRACTION_BITS);
            end else begin
                num     = 64'(gain_avg) * 64'(HUNDRED);
                quot    = (128'(num) << FRACTION_BITS) / (128'(gain_avg) + 128'(loss_avg));
                res.rsi = RSI_BITS'(quot);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsi_expect want;
        if (!i_rst_n) begin
            period_reg   = PERIOD_RESET;
            last_close   = '0;
            seen_changes = '0;
            gain_avg     = '0;
            loss_avg     = '0;
            rsi_expected_q.delete();
            o_outstanding <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                period_reg = i_cfg_period;
            end
            if (i_in_valid && !i_in_stall) begin
                rsi_expected_q.push_back(next_rsi(i_close_price, i_restart));
            end
            if (i_out_valid && !i_out_stall) begin
                if (rsi_expected_q.size() == 0) begin
                    $error("Result transaction arrived with no expectation waiting.");
                    fail_total++;
                end else begin
                    want = rsi_expected_q.pop_front();
                    if (i_rsi_value !== want.rsi) begin
                        $error("rsi_value mismatch: expected %0d, actual %0d",
                               want.rsi, i_rsi_value);
                        fail_total++;
                    end
                    if (i_ready_res !== want.ready) begin
                        $error("ready_res mismatch: expected %0d, actual %0d",
                               want.ready, i_ready_res);
                        fail_total++;
                    end
                end
            end
            o_outstanding <= rsi_expected_q.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Wilder RSI tracker testbench
// Drives directed and random price series through the tracker under several
// period settings, with bursty input traffic and a stalling receiver, and
// reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb;
    import wrsi_pkg::*;

    localparam int unsigned PRICE_BITS    = 32;
    localparam int unsigned FRACTION_BITS = 16;
    localparam int unsigned HOLD_CYCLES   = 1500;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic [PRICE_BITS-1:0]  i_close_price = '0;
    logic                   i_restart     = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic [RSI_BITS-1:0]    o_rsi_value;
    logic                   o_ready_res;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [PERIOD_BITS-1:0] i_cfg_period  = '0;
    logic                   hold_request  = 1'b0;

    int                     fail_count;
    int                     outstanding;
    int                     burst_left    = 0;
    int                     trend         = 0;
    logic [PRICE_BITS-1:0]  walk_price    = '0;

    wilder_rsi_tracker_top #(
        .PRICE_BITS    (PRICE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_close_price (i_close_price),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rsi_value   (o_rsi_value),
        .o_ready_res   (o_ready_res),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_period  (i_cfg_period)
    );

    wrsi_checker #(
        .PRICE_BITS    (PRICE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_close_price (i_close_price),
        .i_restart     (i_restart),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_rsi_value   (o_rsi_value),
        .i_ready_res   (o_ready_res),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_period  (i_cfg_period),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver stalls in episodes of its own; the first episode after the
    // request is one long hold-off so that the tracker backs up its input.
    initial begin : receiver
        int mode;
        int span;
        int k;
        bit long_done;
        long_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request && !long_done) begin
                long_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 9);
                span = $urandom_range(4, 120);
                for (k = 0; k < span; k++) begin
                    case (mode)
                        0, 1, 2: i_out_stall <= 1'b0;
                        3, 4, 5: i_out_stall <= ($urandom_range(0, 3) == 0);
                        6, 7:    i_out_stall <= ($urandom_range(0, 3) != 0);
                        8:       i_out_stall <= k[1];
                        default: i_out_stall <= 1'b1;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_close(input logic [PRICE_BITS-1:0] price, input logic restart);
        int gap;
        i_in_valid    <= 1'b1;
        i_close_price <= price;
        i_restart     <= restart;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PERIOD_BITS-1:0] value);
        i_cfg_valid  <= 1'b1;
        i_cfg_period <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly price walks that start with a restart and run past the period,
    // with trending series to reach a zero average loss, plus some noise.
    task automatic run_series(input logic [PERIOD_BITS-1:0] per, input int count);
        int                    n;
        int                    kind;
        int unsigned           move;
        logic                  restart;
        logic [PRICE_BITS-1:0] price;
        drain_results();
        write_period(per);
        for (n = 0; n < count; n++) begin
            restart = (n == 0) || ($urandom_range(0, 2 * int'(per) + 20) == 0);
            kind = $urandom_range(0, 19);
            if (restart) begin
                trend = $urandom_range(0, 3);
                case ($urandom_range(0, 7))
                    0:       walk_price = '0;
                    1:       walk_price = '1;
                    default: walk_price = $urandom();
                endcase
                price = walk_price;
            end else if (trend >= 2 && kind == 0) begin
                price = $urandom();
            end else if (trend >= 2 && kind == 1) begin
                price = $urandom_range(0, 1) ? '0 : '1;
            end else begin
                move = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1_000_000)
                                                   : $urandom_range(0, 3000);
                case (trend)
                    0:       price = walk_price + move;
                    1:       price = walk_price - move;
                    default: price = $urandom_range(0, 1) ? walk_price + move
                                                          : walk_price - move;
                endcase
            end
            walk_price = price;
            send_close(price, restart);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_close('1, 1'b0);
        send_close('0, 1'b0);
        send_close('0, 1'b0);
        drain_results();
        write_period(8'd2);
        send_close(32'd100, 1'b0);
        send_close(32'd5, 1'b1);
        send_close(32'd7, 1'b0);
        send_close(32'd9, 1'b0);
        send_close(32'd9, 1'b0);
        send_close(32'd3, 1'b0);
        drain_results();
        write_period(8'd1);
        send_close(32'd10, 1'b0);
        send_close(32'd10, 1'b0);
        send_close(32'd2, 1'b0);
        drain_results();
        write_period(8'd0);
        send_close(32'd4, 1'b1);
        send_close(32'd8, 1'b0);
        drain_results();
        write_period(8'd255);
        send_close(32'd12345, 1'b0);
        send_close(32'h8000_0000, 1'b1);
        send_close(32'h7FFF_FFFF, 1'b0);
        drain_results();
        write_period(8'd3);
        send_close(32'd1, 1'b0);
        send_close('1, 1'b0);
        drain_results();

        hold_request <= 1'b1;
        run_series(8'd14, 190);
        run_series(8'd1, 190);
        run_series(8'd255, 320);
        run_series(8'd2, 190);
        run_series(8'($urandom_range(3, 40)), 190);
        run_series(8'd0, 190);
        run_series(8'($urandom_range(1, 255)), 190);
        run_series(8'($urandom_range(5, 20)), 190);
        drain_results();
        repeat (150) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
